### design/lcrl_pkg.sv
// Package for the longest common run length core.
// Holds sizing constants and the command struct sent from the controller to the cell row.
// No dependencies.
`default_nettype none

package lcrl_pkg;

   // Capacity of each sequence, in elements.
   localparam int MAX_LEN = 1024;
   // Element width kept for comparison.
   localparam int ELEM_W = 16;
   // Width of the value field on the input channel.
   localparam int VALUE_W = 16;
   // Width of the length field on the result channel.
   localparam int LEN_W = 11;

   // Cell address width, sequence count width and drain counter width.
   localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int COUNT_W = $clog2(MAX_LEN + 1);
   localparam int RUN_W = COUNT_W;
   localparam int DRAIN_W = IDX_W;

   // Sequence select codes.
   localparam logic SEQ_FIRST = 1'b0;
   localparam logic SEQ_SECOND = 1'b1;

   // Command broadcast to every cell in the same cycle.
   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_idx;
      logic              upd_en;
      logic [ELEM_W-1:0] value;
      logic              drain;
      logic              clear;
   } cell_cmd_type;

endpackage

`default_nettype wire

### design/lcrl_req_if.sv
// Input channel of the longest common run length core: valid/ready plus item fields.
// Depends on lcrl_pkg.
`default_nettype none

interface lcrl_req_if;
   import lcrl_pkg::*;

   logic               valid;
   logic               ready;
   logic               which_seq;
   logic [VALUE_W-1:0] value;
   logic               last;

   modport source (output valid, output which_seq, output value, output last, input ready);
   modport sink (input valid, input which_seq, input value, input last, output ready);
endinterface

`default_nettype wire

### design/lcrl_rsp_if.sv
// Result channel of the longest common run length core: valid/ready plus result fields.
// Depends on lcrl_pkg.
`default_nettype none

interface lcrl_rsp_if;
   import lcrl_pkg::*;

   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] length;
   logic             overflow;

   modport source (output valid, output length, output overflow, input ready);
   modport sink (input valid, input length, input overflow, output ready);
endinterface

`default_nettype wire

### design/longest_common_run_length_core.sv
// Longest common run length core: one item per cycle while loading and streaming.
// After the final item is accepted the best-length maximum sweeps down the cell row;
// the result is ready once it reaches the last cell and the result register is free;
// no item is taken meanwhile; else one item per cycle, set by the cells' row update.
// Synchronous reset clears counters, cell valid bits, runs and bests at once; no sweep.
// Depends on lcrl_pkg, lcrl_req_if, lcrl_rsp_if, lcrl_cell and lcrl_ctrl.
`default_nettype none

module longest_common_run_length_core (
   input wire logic   clock,
   input wire logic   reset,
   lcrl_req_if.sink   req,
   lcrl_rsp_if.source rsp
);
   import lcrl_pkg::*;

   cell_cmd_type     cmd;
   logic [RUN_W-1:0] cell_run  [MAX_LEN];
   logic [RUN_W-1:0] cell_best [MAX_LEN];

   // Counters, drain sequencing and the result register.
   lcrl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .rsp      (rsp),
      .end_best (cell_best[MAX_LEN-1]),
      .cmd      (cmd)
   );

   // Row of cells; each takes its diagonal run and best from its left neighbor.
   for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
      logic [RUN_W-1:0] left_run;
      logic [RUN_W-1:0] left_best;

      if (g == 0) begin : g_head
         assign left_run  = '0;
         assign left_best = '0;
      end else begin : g_body
         assign left_run  = cell_run[g-1];
         assign left_best = cell_best[g-1];
      end

      lcrl_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .cell_idx  (IDX_W'(g)),
         .left_run  (left_run),
         .left_best (left_best),
         .run       (cell_run[g]),
         .best      (cell_best[g])
      );
   end

endmodule

`default_nettype wire

### design/lcrl_cell.sv
// One cell of the run length row: holds one first-sequence element, its run value and
// the largest run seen at this position. Depends on lcrl_pkg.
`default_nettype none

module lcrl_cell (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire lcrl_pkg::cell_cmd_type     cmd,
   input  wire logic [lcrl_pkg::IDX_W-1:0] cell_idx,
   input  wire logic [lcrl_pkg::RUN_W-1:0] left_run,
   input  wire logic [lcrl_pkg::RUN_W-1:0] left_best,
   output logic      [lcrl_pkg::RUN_W-1:0] run,
   output logic      [lcrl_pkg::RUN_W-1:0] best
);
   import lcrl_pkg::*;

   logic              valid_ff, valid_in;
   logic [ELEM_W-1:0] elem_ff, elem_in;
   logic [RUN_W-1:0]  run_ff, run_in;
   logic [RUN_W-1:0]  best_ff, best_in;
   logic              match;

   assign match = (elem_ff == cmd.value);

   // Store on a write to this cell, update the run on a second-sequence item,
   // and fold in the left neighbor's best while draining.
   always_comb begin
      valid_in = valid_ff;
      elem_in  = elem_ff;
      run_in   = run_ff;
      best_in  = best_ff;
      if (cmd.wr_en && (cmd.wr_idx == cell_idx)) begin
         valid_in = 1'b1;
         elem_in  = cmd.value;
         run_in   = '0;
      end
      if (cmd.upd_en && valid_ff) begin
         if (match) begin
            run_in = left_run + RUN_W'(1);
         end else begin
            run_in = '0;
         end
         if (run_in > best_ff) begin
            best_in = run_in;
         end
      end
      if (cmd.drain && (left_best > best_ff)) begin
         best_in = left_best;
      end
   end

   // Control state clears on reset and on the end-of-sequence clear.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         valid_ff <= 1'b0;
         run_ff   <= '0;
         best_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         run_ff   <= run_in;
         best_ff  <= best_in;
      end
   end

   // The element itself needs no reset; it is only read once the cell is valid.
   always_ff @(posedge clock) begin
      elem_ff <= elem_in;
   end

   assign run  = run_ff;
   assign best = best_ff;

endmodule

`default_nettype wire

### design/lcrl_ctrl.sv
// Controller of the longest common run length core: sequence counters, overflow flag,
// drain sequencer and the result register. Depends on lcrl_pkg and the channel interfaces.
`default_nettype none

module lcrl_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   lcrl_req_if.sink                        req,
   lcrl_rsp_if.source                      rsp,
   input  wire logic [lcrl_pkg::RUN_W-1:0] end_best,
   output lcrl_pkg::cell_cmd_type          cmd
);
   import lcrl_pkg::*;

   localparam logic ST_RUN   = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic               state_ff, state_in;
   logic [COUNT_W-1:0] first_count_ff, first_count_in;
   logic [COUNT_W-1:0] second_count_ff, second_count_in;
   logic               overflow_ff, overflow_in;
   logic [DRAIN_W-1:0] drain_cnt_ff, drain_cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0]   rsp_length_ff, rsp_length_in;
   logic               rsp_overflow_ff, rsp_overflow_in;
   logic               accept;
   logic               emit;

   assign req.ready = (state_ff == ST_RUN);
   assign accept    = req.valid && req.ready;

   // The result leaves the drain once the max has reached the last cell and the
   // result register is free or being emptied in this cycle.
   assign emit = (state_ff == ST_DRAIN) && (drain_cnt_ff == '0) &&
                 (!rsp_valid_ff || rsp.ready);

   // Item handling and drain sequencing.
   always_comb begin
      state_in        = state_ff;
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      overflow_in     = overflow_ff;
      drain_cnt_in    = drain_cnt_ff;
      cmd             = '0;
      cmd.wr_idx      = first_count_ff[IDX_W-1:0];
      cmd.value       = req.value[ELEM_W-1:0];

      if (accept) begin
         if (req.which_seq == SEQ_FIRST) begin
            if (first_count_ff < COUNT_W'(MAX_LEN)) begin
               cmd.wr_en      = 1'b1;
               first_count_in = first_count_ff + COUNT_W'(1);
            end else begin
               overflow_in = 1'b1;
            end
         end else begin
            if (second_count_ff < COUNT_W'(MAX_LEN)) begin
               cmd.upd_en      = 1'b1;
               second_count_in = second_count_ff + COUNT_W'(1);
            end else begin
               overflow_in = 1'b1;
            end
            if (req.last) begin
               state_in     = ST_DRAIN;
               drain_cnt_in = DRAIN_W'(MAX_LEN - 1);
            end
         end
      end

      if (state_ff == ST_DRAIN) begin
         cmd.drain = 1'b1;
         if (drain_cnt_ff != '0) begin
            drain_cnt_in = drain_cnt_ff - DRAIN_W'(1);
         end
      end

      if (emit) begin
         cmd.clear       = 1'b1;
         state_in        = ST_RUN;
         first_count_in  = '0;
         second_count_in = '0;
         overflow_in     = 1'b0;
      end
   end

   // Result register: loaded on emit, emptied when the item is taken.
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_length_in   = rsp_length_ff;
      rsp_overflow_in = rsp_overflow_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in    = 1'b1;
         rsp_length_in   = LEN_W'(end_best);
         rsp_overflow_in = overflow_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_RUN;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         overflow_ff     <= 1'b0;
         drain_cnt_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         overflow_ff     <= overflow_in;
         drain_cnt_ff    <= drain_cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_length_ff   <= rsp_length_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.length   = rsp_length_ff;
   assign rsp.overflow = rsp_overflow_ff;

   // Counters never pass capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (first_count_ff <= COUNT_W'(MAX_LEN)) && (second_count_ff <= COUNT_W'(MAX_LEN)))
      else $error("sequence count exceeds capacity");

   // A final second-sequence item always starts the drain.
   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (accept && (req.which_seq == SEQ_SECOND) && req.last) |=> (state_ff == ST_DRAIN))
      else $error("last item did not start the drain");

   // A new result only appears at the end of a drain.
   a_result_from_drain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DRAIN))
      else $error("result raised outside the drain");

   // The clear leaves both sequences empty and the overflow flag low.
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (first_count_ff == '0) && (second_count_ff == '0) && !overflow_ff)
      else $error("state not cleared after result");

endmodule

`default_nettype wire
